[hw/rtl/i2c_master_bit_engine_top_macros.svh]
// Assertion macros, clocked on clk_i and disabled while rst_ni is low.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH

// Condition holds at every edge.
`define I2C_MBE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define I2C_MBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/i2c_mbe_pkg.sv]
package i2c_mbe_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 1'd1;

  localparam logic [15:0] HALF_PERIOD_RST   = 16'd5;
  localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd200;

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_WAIT  = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;

  typedef enum logic [16:0] {
    PH_IDLE  = 17'b00000000000000001,
    PH_ST1   = 17'b00000000000000010,
    PH_ST2   = 17'b00000000000000100,
    PH_SP1   = 17'b00000000000001000,
    PH_SP2   = 17'b00000000000010000,
    PH_WR_LO = 17'b00000000000100000,
    PH_WR_HI = 17'b00000000001000000,
    PH_WN1   = 17'b00000000010000000,
    PH_WN2   = 17'b00000000100000000,
    PH_WN3   = 17'b00000001000000000,
    PH_WA1   = 17'b00000010000000000,
    PH_WA2   = 17'b00000100000000000,
    PH_POLL  = 17'b00001000000000000,
    PH_RD_LO = 17'b00010000000000000,
    PH_RD_HI = 17'b00100000000000000,
    PH_AK_LO = 17'b01000000000000000,
    PH_AK_HI = 17'b10000000000000000
  } phase_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       ack_flag;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } out_item_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] tick_count;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [15:0] poll_count;
    logic        scl;
    logic        sda;
    logic        drv;
    logic        ack_choice;
    logic        error_flag;
    logic [7:0]  rx_hold;
  } eng_state_t;

endpackage

[hw/rtl/i2c_mbe_step.sv]
module i2c_mbe_step import i2c_mbe_pkg::*; (
  input  eng_state_t  state_i,
  input  in_item_t    item_i,
  input  logic [15:0] half_period_i,
  input  logic [15:0] timeout_limit_i,
  output eng_state_t  state_o,
  output logic        done_o
);

  eng_state_t  n;
  logic        done;
  logic [15:0] hp;
  logic [15:0] tick_inc;
  logic [3:0]  bc_inc;

  assign hp       = (half_period_i == 16'd0) ? 16'd1 : half_period_i;
  assign tick_inc = state_i.tick_count + 16'd1;
  assign bc_inc   = state_i.bit_count + 4'd1;

  always_comb begin
    n    = state_i;
    done = 1'b0;
    if (state_i.phase == PH_IDLE) begin
      if (item_i.mode inside {[MODE_START:MODE_READ]}) begin
        n.error_flag = 1'b0;
        n.ack_choice = item_i.ack_flag;
        n.bit_count  = 4'd0;
        n.tick_count = 16'd0;
        case (item_i.mode)
          MODE_START: begin
            n.drv   = 1'b1;
            n.sda   = 1'b1;
            n.scl   = 1'b1;
            n.phase = PH_ST1;
          end
          MODE_STOP: begin
            n.drv   = 1'b1;
            n.scl   = 1'b0;
            n.sda   = 1'b0;
            n.phase = PH_SP1;
          end
          MODE_WRITE: begin
            n.scl       = 1'b0;
            n.drv       = 1'b1;
            n.sda       = item_i.tx_byte[BITS_PER_BYTE-1];
            n.shift_reg = {item_i.tx_byte[BITS_PER_BYTE-2:0], 1'b0};
            n.phase     = PH_WR_LO;
          end
          MODE_WAIT: begin
            if (item_i.ack_flag) begin
              n.drv   = 1'b0;
              n.sda   = 1'b1;
              n.phase = PH_WA1;
            end else begin
              n.phase = PH_WN1;
            end
          end
          default: begin
            n.drv       = 1'b0;
            n.scl       = 1'b0;
            n.shift_reg = 8'd0;
            n.phase     = PH_RD_LO;
          end
        endcase
      end
    end else if (state_i.phase == PH_POLL) begin
      if (!item_i.sda_sample) begin
        n.scl   = 1'b0;
        n.phase = PH_IDLE;
        done    = 1'b1;
      end else if (state_i.poll_count >= timeout_limit_i) begin
        n.error_flag = 1'b1;
        n.drv        = 1'b1;
        n.scl        = 1'b0;
        n.sda        = 1'b0;
        n.tick_count = 16'd0;
        n.phase      = PH_SP1;
      end else begin
        n.poll_count = state_i.poll_count + 16'd1;
      end
    end else if (tick_inc >= hp) begin
      n.tick_count = 16'd0;
      case (state_i.phase)
        PH_ST1: begin
          n.sda   = 1'b0;
          n.phase = PH_ST2;
        end
        PH_ST2: begin
          n.scl   = 1'b0;
          n.phase = PH_IDLE;
          done    = 1'b1;
        end
        PH_SP1: begin
          n.scl   = 1'b1;
          n.sda   = 1'b1;
          n.phase = PH_SP2;
        end
        PH_SP2: begin
          n.phase = PH_IDLE;
          done    = 1'b1;
        end
        PH_WR_LO: begin
          n.scl   = 1'b1;
          n.phase = PH_WR_HI;
        end
        PH_WR_HI: begin
          n.scl       = 1'b0;
          n.bit_count = bc_inc;
          if (bc_inc >= 4'(BITS_PER_BYTE)) begin
            n.phase = PH_IDLE;
            done    = 1'b1;
          end else begin
            n.sda       = state_i.shift_reg[BITS_PER_BYTE-1];
            n.shift_reg = {state_i.shift_reg[BITS_PER_BYTE-2:0], 1'b0};
            n.phase     = PH_WR_LO;
          end
        end
        PH_WN1: begin
          n.scl   = 1'b1;
          n.phase = PH_WN2;
        end
        PH_WN2: begin
          n.scl   = 1'b0;
          n.phase = PH_WN3;
        end
        PH_WN3: begin
          n.phase = PH_IDLE;
          done    = 1'b1;
        end
        PH_WA1: begin
          n.scl   = 1'b1;
          n.phase = PH_WA2;
        end
        PH_WA2: begin
          n.poll_count = 16'd0;
          n.phase      = PH_POLL;
        end
        PH_RD_LO: begin
          n.scl       = 1'b1;
          n.shift_reg = {state_i.shift_reg[BITS_PER_BYTE-2:0], item_i.sda_sample};
          n.phase     = PH_RD_HI;
        end
        PH_RD_HI: begin
          n.scl       = 1'b0;
          n.bit_count = bc_inc;
          if (bc_inc >= 4'(BITS_PER_BYTE)) begin
            n.drv   = 1'b1;
            n.sda   = !state_i.ack_choice;
            n.phase = PH_AK_LO;
          end else begin
            n.phase = PH_RD_LO;
          end
        end
        PH_AK_LO: begin
          n.scl   = 1'b1;
          n.phase = PH_AK_HI;
        end
        PH_AK_HI: begin
          n.scl     = 1'b0;
          n.rx_hold = state_i.shift_reg;
          n.phase   = PH_IDLE;
          done      = 1'b1;
        end
        default: begin
          n.phase = PH_IDLE;
        end
      endcase
    end else begin
      n.tick_count = tick_inc;
    end
  end

  assign state_o = n;
  assign done_o  = done;

endmodule

[hw/rtl/i2c_master_bit_engine_top.sv]
// A result is registered one sequencer pass after its item leaves the input register;
// an output stall holds the item in the input register until the result register frees.
// Throughput: one item per cycle unless the output stalls; the sequencer state advances once per item.
// Output stalls back-pressure through the input register only when both are full.
// Reset (rst_ni low, asynchronous): sequencer idle, SCL/SDA high and driven,
// counters and rx byte zero, half_period 5, timeout_limit 200.
`include "i2c_master_bit_engine_top_macros.svh"

module i2c_master_bit_engine_top import i2c_mbe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  logic        in_valid_q;
  in_item_t    in_q;
  logic        out_valid_q;
  out_item_t   out_q;
  eng_state_t  st_q;
  eng_state_t  st_d;
  logic        done_d;
  logic        step;
  logic [15:0] half_period_q;
  logic [15:0] timeout_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q   <= HALF_PERIOD_RST;
      timeout_limit_q <= TIMEOUT_LIMIT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_HALF_PERIOD) begin
        half_period_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_TIMEOUT_LIMIT) begin
        timeout_limit_q <= cfg_data_i;
      end
    end
  end

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  i2c_mbe_step u_step (
    .state_i         (st_q),
    .item_i          (in_q),
    .half_period_i   (half_period_q),
    .timeout_limit_i (timeout_limit_q),
    .state_o         (st_d),
    .done_o          (done_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_IDLE;
      st_q.tick_count <= 16'd0;
      st_q.bit_count  <= 4'd0;
      st_q.shift_reg  <= 8'd0;
      st_q.poll_count <= 16'd0;
      st_q.scl        <= 1'b1;
      st_q.sda        <= 1'b1;
      st_q.drv        <= 1'b1;
      st_q.ack_choice <= 1'b0;
      st_q.error_flag <= 1'b0;
      st_q.rx_hold    <= 8'd0;
    end else if (step) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.scl_level <= st_d.scl;
      out_q.sda_level <= st_d.sda;
      out_q.sda_drive <= st_d.drv;
      out_q.busy_res  <= (st_d.phase != PH_IDLE);
      out_q.done_res  <= done_d;
      out_q.rx_byte   <= st_d.rx_hold;
      out_q.ack_error <= st_d.error_flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `I2C_MBE_ASSERT_IMPL(a_busy_tracks_phase, out_valid_q, out_q.busy_res == (st_q.phase != PH_IDLE), "busy flag out of step with sequencer")
  `I2C_MBE_ASSERT_IMPL(a_done_not_busy, out_valid_q && out_q.done_res, !out_q.busy_res, "done reported while busy")
  `I2C_MBE_ASSERT(a_bit_count_range, st_q.bit_count <= 4'(BITS_PER_BYTE), "bit count past byte length")
  `I2C_MBE_ASSERT_IMPL(a_error_only_in_stop, st_q.error_flag, st_q.phase == PH_IDLE || st_q.phase == PH_SP1 || st_q.phase == PH_SP2, "error flag outside timeout stop")

endmodule

[dv/testbench.sv]
module testbench;
  import i2c_mbe_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  class bus_level_board;
    phase_e      ph;
    logic [15:0] tick_cnt;
    logic [15:0] half_per;
    logic [15:0] poll_limit;
    logic [15:0] polls;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [7:0]  rx_last;
    logic        scl;
    logic        sda;
    logic        drv;
    logic        ack_sel;
    logic        err;
    out_item_t   expected_levels[$];
    int unsigned mismatches;

    function new();
      ph         = PH_IDLE;
      tick_cnt   = '0;
      bit_cnt    = '0;
      shreg      = '0;
      polls      = '0;
      scl        = 1'b1;
      sda        = 1'b1;
      drv        = 1'b1;
      ack_sel    = 1'b0;
      err        = 1'b0;
      rx_last    = '0;
      half_per   = HALF_PERIOD_RST;
      poll_limit = TIMEOUT_LIMIT_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == CFG_HALF_PERIOD) half_per = val;
      else if (idx == CFG_TIMEOUT_LIMIT) poll_limit = val;
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction

    function void enter_phase(phase_e p);
      ph       = p;
      tick_cnt = '0;
    endfunction

    function void begin_stop();
      drv = 1'b1;
      scl = 1'b0;
      sda = 1'b0;
      enter_phase(PH_SP1);
    endfunction

    function void shift_out();
      sda   = shreg[7];
      shreg = shreg << 1;
    endfunction

    // end of a half phase; returns 1 when the command completes
    function bit end_half_phase();
      case (ph)
        PH_ST1: begin
          sda = 1'b0;
          enter_phase(PH_ST2);
        end
        PH_ST2: begin
          scl = 1'b0;
          ph  = PH_IDLE;
          return 1'b1;
        end
        PH_SP1: begin
          scl = 1'b1;
          sda = 1'b1;
          enter_phase(PH_SP2);
        end
        PH_SP2: begin
          ph = PH_IDLE;
          return 1'b1;
        end
        PH_WR_LO: begin
          scl = 1'b1;
          enter_phase(PH_WR_HI);
        end
        PH_WR_HI: begin
          scl     = 1'b0;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= BITS_PER_BYTE) begin
            ph = PH_IDLE;
            return 1'b1;
          end
          shift_out();
          enter_phase(PH_WR_LO);
        end
        PH_WN1: begin
          scl = 1'b1;
          enter_phase(PH_WN2);
        end
        PH_WN2: begin
          scl = 1'b0;
          enter_phase(PH_WN3);
        end
        PH_WN3: begin
          ph = PH_IDLE;
          return 1'b1;
        end
        PH_WA1: begin
          scl = 1'b1;
          enter_phase(PH_WA2);
        end
        PH_WA2: begin
          polls = '0;
          enter_phase(PH_POLL);
        end
        PH_RD_LO: begin
          scl = 1'b1;
          enter_phase(PH_RD_HI);
        end
        PH_RD_HI: begin
          scl     = 1'b0;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= BITS_PER_BYTE) begin
            drv = 1'b1;
            sda = ~ack_sel;
            enter_phase(PH_AK_LO);
          end else begin
            enter_phase(PH_RD_LO);
          end
        end
        PH_AK_LO: begin
          scl = 1'b1;
          enter_phase(PH_AK_HI);
        end
        PH_AK_HI: begin
          scl     = 1'b0;
          rx_last = shreg;
          ph      = PH_IDLE;
          return 1'b1;
        end
        default: ph = PH_IDLE;
      endcase
      return 1'b0;
    endfunction

    function void start_command(in_item_t it);
      if (it.mode < MODE_START || it.mode > MODE_READ) return;
      err     = 1'b0;
      ack_sel = it.ack_flag;
      bit_cnt = '0;
      case (it.mode)
        MODE_START: begin
          drv = 1'b1;
          sda = 1'b1;
          scl = 1'b1;
          enter_phase(PH_ST1);
        end
        MODE_STOP: begin_stop();
        MODE_WRITE: begin
          scl   = 1'b0;
          drv   = 1'b1;
          shreg = it.tx_byte;
          shift_out();
          enter_phase(PH_WR_LO);
        end
        MODE_WAIT: begin
          if (it.ack_flag) begin
            drv = 1'b0;
            sda = 1'b1;
            enter_phase(PH_WA1);
          end else begin
            enter_phase(PH_WN1);
          end
        end
        default: begin
          drv   = 1'b0;
          scl   = 1'b0;
          shreg = '0;
          enter_phase(PH_RD_LO);
        end
      endcase
    endfunction

    function void predict_tick(in_item_t it);
      out_item_t   lv;
      logic        fin;
      phase_e      was;
      logic [15:0] hp;
      fin = 1'b0;
      if (ph == PH_IDLE) begin
        start_command(it);
      end else if (ph == PH_POLL) begin
        if (!it.sda_sample) begin
          scl = 1'b0;
          ph  = PH_IDLE;
          fin = 1'b1;
        end else if (polls >= poll_limit) begin
          err = 1'b1;
          begin_stop();
        end else begin
          polls = polls + 16'd1;
        end
      end else begin
        hp       = (half_per == '0) ? 16'd1 : half_per;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= hp) begin
          was      = ph;
          tick_cnt = '0;
          fin      = end_half_phase();
          if (was == PH_RD_LO) shreg = {shreg[6:0], it.sda_sample};
        end
      end
      lv.scl_level = scl;
      lv.sda_level = sda;
      lv.sda_drive = drv;
      lv.busy_res  = (ph != PH_IDLE);
      lv.done_res  = fin;
      lv.rx_byte   = rx_last;
      lv.ack_error = err;
      expected_levels.push_back(lv);
    endfunction

    function void compare_levels(out_item_t got);
      out_item_t want;
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: scl %b sda %b drv %b busy %b done %b rx %02h err %b",
                   got.scl_level, got.sda_level, got.sda_drive, got.busy_res,
                   got.done_res, got.rx_byte, got.ack_error);
        return;
      end
      want = expected_levels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: scl %b sda %b drv %b busy %b done %b rx %02h err %b",
                   want.scl_level, want.sda_level, want.sda_drive, want.busy_res,
                   want.done_res, want.rx_byte, want.ack_error);
          $display("         got: scl %b sda %b drv %b busy %b done %b rx %02h err %b",
                   got.scl_level, got.sda_level, got.sda_drive, got.busy_res,
                   got.done_res, got.rx_byte, got.ack_error);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]          cfg_data_i;

  bus_level_board board = new();

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned ack_low_pct    = 100;
  int unsigned items_sent     = 0;
  bit          hold_req       = 1'b0;

  i2c_master_bit_engine_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[i2c_master_bit_engine_top] ERROR");
    $finish;
  end

  // result side: check, then pick ready for the next edge
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) board.compare_levels(out_data_o);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = 80;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic logic sda_for_tick();
    if (board.ph == PH_POLL) return ($urandom_range(99) < ack_low_pct) ? 1'b0 : 1'b1;
    return 1'($urandom_range(1));
  endfunction

  function automatic in_item_t busy_tick();
    in_item_t it;
    it.mode       = 3'($urandom_range(7));
    it.tx_byte    = 8'($urandom_range(255));
    it.ack_flag   = 1'($urandom_range(1));
    it.sda_sample = sda_for_tick();
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.predict_tick(it);
    items_sent++;
  endtask

  // one command, then ticks until the engine is idle again
  task automatic issue(input logic [2:0] mode, input logic [7:0] tx, input logic ack);
    in_item_t it;
    it.mode       = mode;
    it.tx_byte    = tx;
    it.ack_flag   = ack;
    it.sda_sample = sda_for_tick();
    send_item(it);
    while (board.ph != PH_IDLE) send_item(busy_tick());
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [15:0] hp, input logic [15:0] tl);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_HALF_PERIOD;
    cfg_data_i  <= hp;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(CFG_HALF_PERIOD, hp);
    cfg_index_i <= CFG_TIMEOUT_LIMIT;
    cfg_data_i  <= tl;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(CFG_TIMEOUT_LIMIT, tl);
    cfg_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic run_transfer();
    int unsigned n;
    n = $urandom_range(3, 1);
    issue(MODE_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
    issue(MODE_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
    issue(MODE_WAIT, 8'($urandom_range(255)), 1'b1);
    repeat (n) begin
      if ($urandom_range(1) == 0) begin
        issue(MODE_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        issue(MODE_WAIT, 8'($urandom_range(255)), ($urandom_range(7) != 0));
      end else begin
        issue(MODE_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    issue(MODE_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) == 0)
        issue(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        run_transfer();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, reset settings
    issue(MODE_START, 8'h00, 1'b0);
    issue(MODE_WRITE, 8'h00, 1'b0);
    issue(MODE_WAIT, 8'hFF, 1'b1);
    issue(MODE_WRITE, 8'hFF, 1'b1);
    issue(MODE_WAIT, 8'h00, 1'b0);
    issue(MODE_READ, 8'h5A, 1'b1);
    issue(MODE_READ, 8'hA5, 1'b0);
    issue(MODE_SPARE6, 8'hFF, 1'b1);
    issue(MODE_SPARE7, 8'h00, 1'b0);
    issue(MODE_NONE, 8'hC3, 1'b1);
    issue(MODE_WRITE, 8'h81, 1'b0);
    ack_low_pct = 0;
    issue(MODE_WAIT, 8'h3C, 1'b1);
    ack_low_pct = 100;
    issue(MODE_NONE, 8'h00, 1'b0);
    issue(MODE_STOP, 8'h7E, 1'b1);

    reconfigure(16'd1, 16'd0);
    src_idle_pct = 51;
    ack_low_pct  = 50;
    run_random(60);

    reconfigure(16'd0, 16'd3);
    src_idle_pct   = 0;
    sink_stall_pct = 51;
    ack_low_pct    = 30;
    run_random(60);

    reconfigure(16'd2, 16'hFFFF);
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    ack_low_pct    = 20;
    hold_req       = 1'b1;
    run_random(30);
    drain_results();
    run_random(30);

    reconfigure(16'd3, 16'd1);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    ack_low_pct    = 40;
    run_random(40);

    // long half phase: a single stop
    reconfigure(16'd20, 16'hFFFF);
    issue(MODE_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));

    drain_results();
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[i2c_master_bit_engine_top] OK");
    end else begin
      $display("[i2c_master_bit_engine_top] ERROR");
    end
    $finish;
  end
endmodule
